/* rtl/core/esp_pkg.sv */
// ---------------------------------------------------------------------------
// esp_pkg: shared types and constants for the encoder speed PID block
// Command and status words between controller and datapath, datapath
// operation codes, register indexes and fixed-point constants.
// ---------------------------------------------------------------------------
package esp_pkg;

	localparam int GAIN_W   = 24;
	localparam int CNT_W    = 16;
	localparam int DUTY_W   = 14;
	localparam int SPEED_W  = 21;
	localparam int ERR_W    = 22;
	localparam int DERR_W   = 23;
	localparam int INTEG_W  = 48;
	localparam int PROD_W   = 48;
	localparam int ACC_W    = 64;
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD = 2'd2;

	localparam logic [GAIN_W-1:0] KP_RESET = 24'd6554;

	// one unit of drive is 65536 * 100 fraction steps
	localparam logic signed [ACC_W-1:0] FRAC_SCALE = 64'sd6553600;

	// ceil(2^30 / 100): exact quotient by 100 for inputs below 2^23
	localparam logic [GAIN_W-1:0] RECIP_100 = 24'd10737419;
	localparam int RECIP_SHIFT = 30;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MKD,
		OP_MKP,
		OP_MKI,
		OP_INT,
		OP_SUM,
		OP_RCP,
		OP_FIN
	} op_t;

	typedef struct packed {
		logic ready;
		op_t  op;
	} esp_cmd_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} esp_stat_t;

endpackage

/* rtl/core/esp_if.sv */
// ---------------------------------------------------------------------------
// esp_if: handshake channels of the encoder speed PID block
// One channel for sampling ticks, one for result words.
// ---------------------------------------------------------------------------
interface esp_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] encoder_count;
	logic [15:0] desired_speed;

	modport source(output valid, output encoder_count, output desired_speed, input ready);
	modport sink(input valid, input encoder_count, input desired_speed, output ready);
endinterface

interface esp_result_if;
	logic        valid;
	logic        ready;
	logic [13:0] duty;
	logic        duty_written;
	logic [20:0] measured_speed;

	modport source(output valid, output duty, output duty_written, output measured_speed,
		input ready);
	modport sink(input valid, input duty, input duty_written, input measured_speed,
		output ready);
endinterface

/* rtl/core/esp_ctrl.sv */
// ---------------------------------------------------------------------------
// esp_ctrl: sequencer of the encoder speed PID block
// Steps the datapath through one tick's operations and owns input ready.
// ---------------------------------------------------------------------------
module esp_ctrl import esp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  esp_stat_t stat,
	output esp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MKD,
		S_MKP,
		S_MKI,
		S_INT,
		S_SUM,
		S_RCP,
		S_FIN
	} state_t;

	state_t   state_q;
	esp_cmd_t cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q.ready <= 1'b1;
			cmd_q.op    <= OP_NONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (stat.start) begin
						state_q     <= S_MKD;
						cmd_q.ready <= 1'b0;
						cmd_q.op    <= OP_MKD;
					end
				end
				S_MKD: begin
					state_q  <= S_MKP;
					cmd_q.op <= OP_MKP;
				end
				S_MKP: begin
					state_q  <= S_MKI;
					cmd_q.op <= OP_MKI;
				end
				S_MKI: begin
					state_q  <= S_INT;
					cmd_q.op <= OP_INT;
				end
				S_INT: begin
					state_q  <= S_SUM;
					cmd_q.op <= OP_SUM;
				end
				S_SUM: begin
					state_q  <= S_RCP;
					cmd_q.op <= OP_RCP;
				end
				S_RCP: begin
					state_q  <= S_FIN;
					cmd_q.op <= OP_FIN;
				end
				S_FIN: begin
					// hold until the output register can take the word
					if (stat.out_free) begin
						state_q     <= S_IDLE;
						cmd_q.ready <= 1'b1;
						cmd_q.op    <= OP_NONE;
					end
				end
			endcase
		end
	end

	assign cmd = cmd_q;

endmodule

/* rtl/core/esp_dp.sv */
// ---------------------------------------------------------------------------
// esp_dp: datapath of the encoder speed PID block
// Gain registers, controller state, one shared multiplier, accumulator,
// reciprocal divide by 100 and the output register.
// ---------------------------------------------------------------------------
module esp_dp import esp_pkg::*; #(
	parameter int PWM_TOP = 15000
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [GAIN_W-1:0]    wr_data,
	input  logic                 load,
	input  logic [CNT_W-1:0]     encoder_count,
	input  logic [CNT_W-1:0]     desired_speed,
	input  op_t                  op,
	input  logic                 out_ready,
	output logic                 out_free,
	output logic                 out_valid,
	output logic [DUTY_W-1:0]    duty,
	output logic                 duty_written,
	output logic [SPEED_W-1:0]   measured_speed
);

	localparam int DRV_W = $clog2(PWM_TOP);
	localparam int QIN_W = $clog2(PWM_TOP * 100);
	localparam logic signed [ACC_W-1:0] TOP_SCALE = 64'(PWM_TOP) * 64'd6553600;
	localparam logic [DRV_W-1:0] DRV_MAX = DRV_W'(PWM_TOP - 1);

	function automatic logic signed [ACC_W-1:0] times100(input logic signed [ACC_W-1:0] v);
		return (v <<< 6) + (v <<< 5) + (v <<< 2);
	endfunction

	logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [CNT_W-1:0]  last_count_q;
	logic signed [ERR_W-1:0]   last_err_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic [DRV_W-1:0]          drive_q;
	logic                      out_valid_q;

	logic [SPEED_W-1:0]        speed_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DERR_W-1:0]  derr_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      low_q, high_q;
	logic [DUTY_W-1:0]         duty_q;
	logic                      written_q;
	logic [SPEED_W-1:0]        speed_out_q;

	logic [CNT_W-1:0]          diff;
	logic [SPEED_W-1:0]        speed;
	logic signed [ERR_W-1:0]   err;
	logic signed [DERR_W-1:0]  derr;
	logic signed [24:0]        mul_a;
	logic signed [23:0]        mul_b;
	logic signed [48:0]        mul_p;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_next;
	logic [ACC_W-1:0]          drv_term;
	logic [QIN_W-1:0]          quo_in;
	logic [DRV_W-1:0]          quo;
	logic [DRV_W-1:0]          next_drive;
	logic [DRV_W+DUTY_W-1:0]   duty_ext;
	logic                      fire;

	// speed and error of the incoming tick
	assign diff  = encoder_count - last_count_q;
	assign speed = ({5'b0, diff} << 5) - ({5'b0, diff} << 1);
	assign err   = $signed({6'b0, desired_speed}) - $signed({1'b0, speed});
	assign derr  = {err[ERR_W-1], err} - {last_err_q[ERR_W-1], last_err_q};

	// shared multiplier operand select
	always_comb begin
		unique case (op)
			OP_MKD: begin
				mul_a = $signed({1'b0, kd_q});
				mul_b = $signed({derr_q[DERR_W-1], derr_q});
			end
			OP_MKP: begin
				mul_a = $signed({1'b0, kp_q});
				mul_b = $signed({{2{err_q[ERR_W-1]}}, err_q});
			end
			OP_MKI: begin
				mul_a = $signed({1'b0, ki_q});
				mul_b = $signed({{2{err_q[ERR_W-1]}}, err_q});
			end
			OP_RCP: begin
				mul_a = $signed({1'b0, RECIP_100});
				mul_b = $signed(24'(quo_in));
			end
			default: begin
				mul_a = $signed({1'b0, kp_q});
				mul_b = $signed({{2{err_q[ERR_W-1]}}, err_q});
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// integral with saturation at the 48-bit limits
	assign integ_sum = {integ_q[INTEG_W-1], integ_q} + {prod_q[PROD_W-1], prod_q};
	always_comb begin
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
			integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
			                                : {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			integ_next = integ_sum[INTEG_W-1:0];
		end
	end

	// drive * 100 * 65536
	assign drv_term = (64'(drive_q) << 22) + (64'(drive_q) << 21) + (64'(drive_q) << 18);

	assign quo_in = acc_q[16 +: QIN_W];
	assign quo    = prod_q[RECIP_SHIFT +: DRV_W];

	always_comb begin
		priority if (high_q) begin
			next_drive = DRV_MAX;
		end else if (low_q) begin
			next_drive = '0;
		end else begin
			next_drive = quo;
		end
	end

	assign duty_ext = (DRV_W + DUTY_W)'(next_drive);
	assign out_free = !out_valid_q || out_ready;
	assign fire     = (op == OP_FIN) && out_free;

	// configuration and tick-to-tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q         <= KP_RESET;
			ki_q         <= '0;
			kd_q         <= '0;
			last_count_q <= '0;
			last_err_q   <= '0;
			integ_q      <= '0;
			drive_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_KP:  kp_q <= wr_data;
					REG_KI:  ki_q <= wr_data;
					REG_KD:  kd_q <= wr_data;
					default: ;
				endcase
			end
			if (load) begin
				last_count_q <= encoder_count;
				last_err_q   <= err;
			end
			if (op == OP_INT) begin
				integ_q <= integ_next;
			end
			if (fire) begin
				drive_q     <= next_drive;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (load) begin
			speed_q <= speed;
			err_q   <= err;
			derr_q  <= derr;
		end
		unique case (op)
			OP_MKD: begin
				prod_q <= $signed(mul_p[PROD_W-1:0]);
			end
			OP_MKP: begin
				acc_q  <= {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
				prod_q <= $signed(mul_p[PROD_W-1:0]);
			end
			OP_MKI: begin
				acc_q  <= times100(acc_q) + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
				prod_q <= $signed(mul_p[PROD_W-1:0]);
			end
			OP_INT: begin
				acc_q <= times100(acc_q) + $signed(drv_term);
			end
			OP_SUM: begin
				acc_q <= acc_q + {{(ACC_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
			end
			OP_RCP: begin
				low_q  <= acc_q < FRAC_SCALE;
				high_q <= acc_q >= TOP_SCALE;
				prod_q <= $signed(mul_p[PROD_W-1:0]);
			end
			default: ;
		endcase
		if (fire) begin
			duty_q      <= duty_ext[DUTY_W-1:0];
			written_q   <= !low_q && !high_q;
			speed_out_q <= speed_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign duty           = duty_q;
	assign duty_written   = written_q;
	assign measured_speed = speed_out_q;

endmodule

/* rtl/core/encoder_speed_pid_pwm.sv */
// ---------------------------------------------------------------------------
// encoder_speed_pid_pwm: incremental PID speed controller
// Measures speed from encoder counter deltas and updates a clamped PWM drive
// value once per sampling tick.
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake      word
//   -------   ---   ------------   ------------------------------------------
//   sample    in    valid/ready    encoder_count[15:0], desired_speed[15:0]
//   result    out   valid/ready    duty[13:0], duty_written, measured_speed[20:0]
//   wr_*      in    wr_en          wr_index[1:0] (kp, ki, kd), wr_data[23:0]
//
// Ready drops from accept until the tick is through seven steps on the
// single shared 25x24 multiplier (kd, kp, ki products and the reciprocal
// divide by 100) and the 64-bit accumulator; no new sample enters meanwhile.
// The result word is registered; a waiting result stalls only the last step.
// Reset clears gains to their defaults, the tick state and the output valid.
//
module encoder_speed_pid_pwm import esp_pkg::*; #(
	parameter int PWM_TOP = 15000
) (
	input  logic                 clk,
	input  logic                 arst_n,
	esp_sample_if.sink           sample,
	esp_result_if.source         result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [GAIN_W-1:0]    wr_data
);

	esp_cmd_t  cmd;
	esp_stat_t stat;
	logic      accept;
	logic      out_free;

	// a word enters only while the sequencer sits idle
	assign sample.ready = cmd.ready;
	assign accept       = sample.valid && cmd.ready;

	assign stat.start    = accept;
	assign stat.out_free = out_free;

	esp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	esp_dp #(
		.PWM_TOP (PWM_TOP)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.load           (accept),
		.encoder_count  (sample.encoder_count),
		.desired_speed  (sample.desired_speed),
		.op             (cmd.op),
		.out_ready      (result.ready),
		.out_free       (out_free),
		.out_valid      (result.valid),
		.duty           (result.duty),
		.duty_written   (result.duty_written),
		.measured_speed (result.measured_speed)
	);

	// drop ready for the whole tick once a word is taken
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample.ready)
		else $error("sample accepted while a tick was still in progress");

	// the sequencer issues commands only while busy
	a_ready_no_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (cmd.op == OP_NONE))
		else $error("datapath command issued while idle");

	// a finishing step with room in the output register yields a result
	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FIN) && out_free |=> result.valid)
		else $error("final step did not load the result register");

	// a new result appears only from the final step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.op == OP_FIN))
		else $error("result valid rose outside the final step");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the encoder speed PID controller
// Streams sampling ticks through the sample channel, predicts every result
// word from a cycle-free model of the controller and compares each word that
// leaves the result channel. Gains change between phases while the block is
// idle. Sender gaps and receiver stalls vary from phase to phase.
// ---------------------------------------------------------------------------
module testbench;
	import esp_pkg::*;

	localparam int PWM_TOP = 15000;
	// cycles with no word moving on either channel before the run is declared hung
	localparam int IDLE_LIMIT = 2000;
	// quiet cycles after the last result
	localparam int DRAIN_CYCLES = 16;
	localparam int NUM_PHASES = 8;
	// index 3 maps to no register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
	localparam longint SPEED_PER_COUNT = 30;
	localparam longint DRIVE_UNIT = FRAC_SCALE;
	localparam longint INTEG_MAX = 64'sd140737488355327;
	localparam longint INTEG_MIN = -64'sd140737488355328;

	typedef enum logic [1:0] {
		SHAPE_MIX,
		SHAPE_PUSH_UP,
		SHAPE_PULL_DOWN
	} shape_t;

	typedef struct packed {
		logic [CNT_W-1:0] encoder_count;
		logic [CNT_W-1:0] desired_speed;
	} sample_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic               duty_written;
		logic [SPEED_W-1:0] measured_speed;
	} drive_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [GAIN_W-1:0]    wr_data;

	esp_sample_if sample_ch();
	esp_result_if result_ch();

	encoder_speed_pid_pwm #(
		.PWM_TOP(PWM_TOP)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// ticks waiting for the driver, and result words owed by the block
	sample_word_t tick_q[$];
	drive_word_t  duty_expect_q[$];

	// controller image: gains and per-tick state, kept in step with the block
	logic [GAIN_W-1:0]         kp_now;
	logic [GAIN_W-1:0]         ki_now;
	logic [GAIN_W-1:0]         kd_now;
	logic [CNT_W-1:0]          prev_count;
	logic signed [ERR_W-1:0]   prev_error;
	logic signed [INTEG_W-1:0] integ_acc;
	logic [DUTY_W-1:0]         drive_now;

	// encoder position of the well-formed tick stream
	logic [CNT_W-1:0] enc_pos;

	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	sample_word_t drv_word;
	drive_word_t  got_exp;

	// -----------------------------------------------------------------------
	// Controller prediction. All terms are in 1/6553600 of a drive step:
	// P = kp*e*100, D = kd*(e - last e)*10000, I accumulates ki*e and
	// saturates at the signed 48-bit limits. The new drive is truncated
	// toward zero, flagged as written when strictly inside (0, PWM_TOP),
	// then clamped to 0..PWM_TOP-1.
	// -----------------------------------------------------------------------
	function automatic drive_word_t predict_drive(input sample_word_t w);
		logic [CNT_W-1:0] delta;
		longint speed;
		longint err;
		longint integ;
		longint total;
		longint level;
		drive_word_t r;

		// the 16-bit wrap makes a counter rolling past zero count forward
		delta = w.encoder_count - prev_count;
		speed = longint'({48'd0, delta}) * SPEED_PER_COUNT;
		err = longint'({48'd0, w.desired_speed}) - speed;

		integ = longint'(integ_acc) + longint'({40'd0, ki_now}) * err;
		if (integ > INTEG_MAX)
			integ = INTEG_MAX;
		else if (integ < INTEG_MIN)
			integ = INTEG_MIN;

		total = longint'({50'd0, drive_now}) * DRIVE_UNIT
			+ longint'({40'd0, kp_now}) * err * 100
			+ longint'({40'd0, kd_now}) * (err - longint'(prev_error)) * 10000
			+ integ;
		level = total / DRIVE_UNIT;

		prev_count = w.encoder_count;
		prev_error = err[ERR_W-1:0];
		integ_acc = integ[INTEG_W-1:0];

		r.duty_written = (level > 0) && (level < PWM_TOP);
		if (level >= PWM_TOP)
			level = PWM_TOP - 1;
		if (level < 0)
			level = 0;
		drive_now = level[DUTY_W-1:0];

		r.duty = level[DUTY_W-1:0];
		r.measured_speed = speed[SPEED_W-1:0];
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Tick shapes. The mixed stream is mostly plausible motion: small forward
	// counts and targets in the same range, so the drive moves around inside
	// its band. The rest holds the counter, jumps it anywhere, or steps it
	// back by a little, which reads as nearly a full wrap of fast motion.
	// Push-up and pull-down drive the integral to either saturation limit.
	// -----------------------------------------------------------------------
	function automatic sample_word_t shape_tick(input shape_t shape);
		sample_word_t w;
		int unsigned pick;

		pick = $urandom_range(99);
		case (shape)
			SHAPE_PUSH_UP: begin
				w.encoder_count = enc_pos;
				w.desired_speed = '1;
			end
			SHAPE_PULL_DOWN: begin
				enc_pos = enc_pos - 1'b1;
				w.encoder_count = enc_pos;
				w.desired_speed = '0;
			end
			default: begin
				if (pick < 70) begin
					enc_pos = enc_pos + CNT_W'($urandom_range(220));
					w.desired_speed = CNT_W'($urandom_range(6600));
				end else if (pick < 80) begin
					w.desired_speed = CNT_W'($urandom);
				end else if (pick < 92) begin
					enc_pos = CNT_W'($urandom);
					w.desired_speed = CNT_W'($urandom);
				end else begin
					enc_pos = enc_pos - CNT_W'($urandom_range(30, 1));
					w.desired_speed = CNT_W'($urandom);
				end
				w.encoder_count = enc_pos;
			end
		endcase
		return w;
	endfunction

	function automatic void queue_tick(input logic [CNT_W-1:0] count,
		input logic [CNT_W-1:0] target);
		sample_word_t w;

		w.encoder_count = count;
		w.desired_speed = target;
		tick_q.push_back(w);
	endfunction

	// Write one gain register and mirror it; only called while the block is idle.
	task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_KP: kp_now = val;
			REG_KI: ki_now = val;
			REG_KD: kd_now = val;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Hold until every queued tick is taken and every result word is back,
	// then let the block settle before anything else changes.
	task automatic wait_drained();
		while (tick_q.size() != 0 || sample_ch.valid || duty_expect_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Sample driver: offer the next tick whenever the channel is free, with
	// random gaps at the phase's idle rate. valid gets exactly one update per
	// edge so a word that follows directly keeps valid high.
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.encoder_count <= '0;
			sample_ch.desired_speed <= '0;
		end else if (!sample_ch.valid || sample_ch.ready) begin
			if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				drv_word = tick_q.pop_front();
				sample_ch.valid <= 1'b1;
				sample_ch.encoder_count <= drv_word.encoder_count;
				sample_ch.desired_speed <= drv_word.desired_speed;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: drop ready at the phase's stall rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: retire the result word first, since a word leaving at this
	// edge always belongs to an older tick than one entering. Then predict
	// the tick accepted at this edge. The watchdog counts edges at which no
	// word moves on either channel.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (duty_expect_q.size() == 0) begin
					$error("unexpected result word: duty %0d, duty_written %0b, measured_speed %0d",
						result_ch.duty, result_ch.duty_written, result_ch.measured_speed);
					mismatch_count++;
				end else begin
					got_exp = duty_expect_q.pop_front();
					if (result_ch.duty !== got_exp.duty) begin
						$error("duty: expected %0d, got %0d", got_exp.duty, result_ch.duty);
						mismatch_count++;
					end
					if (result_ch.duty_written !== got_exp.duty_written) begin
						$error("duty_written: expected %0b, got %0b",
							got_exp.duty_written, result_ch.duty_written);
						mismatch_count++;
					end
					if (result_ch.measured_speed !== got_exp.measured_speed) begin
						$error("measured_speed: expected %0d, got %0d",
							got_exp.measured_speed, result_ch.measured_speed);
						mismatch_count++;
					end
				end
			end

			if (sample_ch.valid && sample_ch.ready)
				duty_expect_q.push_back(predict_drive({sample_ch.encoder_count,
					sample_ch.desired_speed}));

			if ((result_ch.valid && result_ch.ready) || (sample_ch.valid && sample_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;

			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Sequence: reset, a directed run on the reset gains, then phases with
	// fresh gains and idle patterns. Each phase ends with the sender paused
	// until every result word is back, which also makes the gain writes safe.
	// -----------------------------------------------------------------------
	initial begin
		int unsigned n_items;
		logic [GAIN_W-1:0] g_kp;
		logic [GAIN_W-1:0] g_ki;
		logic [GAIN_W-1:0] g_kd;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_KP;
		wr_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		mismatch_count = 0;
		quiet_cycles = 0;

		kp_now = KP_RESET;
		ki_now = '0;
		kd_now = '0;
		prev_count = '0;
		prev_error = '0;
		integ_acc = '0;
		drive_now = '0;
		enc_pos = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed run on the reset gains, no idling
		@(negedge clk);
		queue_tick(16'd0, 16'd0);          // all zero: no motion, no target
		queue_tick(16'd0, 16'hFFFF);       // largest positive error, drive climbs
		queue_tick(16'd0, 16'hFFFF);
		queue_tick(16'd0, 16'hFFFF);       // overshoots the top: clamp, no update
		queue_tick(16'd0, 16'hFFFF);       // stays pinned at the top
		queue_tick(16'hFFFF, 16'd0);       // largest count step: most negative error
		queue_tick(16'hFFFF, 16'd0);       // drive sits at zero, no update
		queue_tick(16'd5, 16'd0);          // counter wraps past zero: forward 6
		queue_tick(16'd5, 16'd150);        // small positive error, drive inside band
		queue_tick(16'd15, 16'd300);       // speed meets target: zero error
		queue_tick(16'd25, 16'd0);         // negative error pulls back to zero
		queue_tick(16'h8000, 16'h5555);    // alternate bit patterns
		queue_tick(16'h8000, 16'hAAAA);
		queue_tick(16'h7FFF, 16'h5555);    // step back by one: near full wrap
		queue_tick(16'h7FFF, 16'hFFFF);
		queue_tick(16'h7FFF, 16'd1);       // smallest nonzero target
		queue_tick(16'h8001, 16'd60);      // target exactly equals speed
		queue_tick(16'h0001, 16'd40000);
		queue_tick(16'h0002, 16'd6000);
		queue_tick(16'h0002, 16'd0);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			n_items = 250;
			case (p)
				0: begin g_kp = KP_RESET; g_ki = '0; g_kd = '0; n_items = 200; end
				1: begin g_kp = '0; g_ki = '0; g_kd = '0; n_items = 150; end
				2: begin g_kp = GAIN_MAX; g_ki = GAIN_MAX; g_kd = GAIN_MAX; n_items = 150; end
				3: begin g_kp = 24'd6554; g_ki = 24'd655; g_kd = 24'd3277; end
				4: begin g_kp = '0; g_ki = GAIN_MAX; g_kd = '0; n_items = 0; end
				5: begin
					g_kp = GAIN_W'($urandom_range(65536));
					g_ki = GAIN_W'($urandom_range(65536));
					g_kd = GAIN_W'($urandom_range(65536));
				end
				6: begin
					g_kp = GAIN_W'($urandom_range(1 << 20));
					g_ki = GAIN_W'($urandom_range(4096));
					g_kd = GAIN_W'($urandom_range(16384));
				end
				default: begin g_kp = GAIN_MAX; g_ki = '0; g_kd = '0; n_items = 200; end
			endcase

			write_gain(REG_KP, g_kp);
			write_gain(REG_KI, g_ki);
			write_gain(REG_KD, g_kd);
			if (p == NUM_PHASES - 1)
				write_gain(REG_SPARE, GAIN_W'($urandom));

			// set the idle pattern away from the rising edge
			@(negedge clk);
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 51; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 51; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase

			if (p == 4) begin
				// hold the error at its largest until the integral pins high,
				// then flip it hard until it pins low
				for (int i = 0; i < 140; i++)
					tick_q.push_back(shape_tick(SHAPE_PUSH_UP));
				for (int i = 0; i < 20; i++)
					tick_q.push_back(shape_tick(SHAPE_PULL_DOWN));
			end
			for (int i = 0; i < n_items; i++)
				tick_q.push_back(shape_tick(SHAPE_MIX));

			wait_drained();
		end

		if (duty_expect_q.size() != 0) begin
			$error("%0d result words never arrived", duty_expect_q.size());
			mismatch_count++;
		end

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/core/esp_pkg.sv
rtl/core/esp_if.sv
rtl/core/esp_ctrl.sv
rtl/core/esp_dp.sv
rtl/core/encoder_speed_pid_pwm.sv
tb/testbench.sv
